>>> src/wcfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the write-coils frame checker.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package wcfc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [8:0] PosData       = 9'd7;
  localparam logic [8:0] FrameOverhead = 9'd9;

  localparam logic [2:0] PosSlave     = 3'd0;
  localparam logic [2:0] PosFunction  = 3'd1;
  localparam logic [2:0] PosOffsetHi  = 3'd2;
  localparam logic [2:0] PosOffsetLo  = 3'd3;
  localparam logic [2:0] PosCountHi   = 3'd4;
  localparam logic [2:0] PosCountLo   = 3'd5;

  localparam logic [15:0] MinCoilReset = 16'd1;
  localparam logic [15:0] MaxCoilReset = 16'd1968;

  localparam int unsigned DefQueueDepth = 2;
  localparam int unsigned OutDataW      = 80;

  localparam logic CfgMinCoil = 1'b0;
  localparam logic CfgMaxCoil = 1'b1;

  typedef enum logic {
    KindData    = 1'b0,
    KindVerdict = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StCrc     = 3'd1,
    StLow     = 3'd2,
    StHigh    = 3'd3,
    StByteCnt = 3'd4
  } status_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic        crc_ok;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] offset;
    logic [15:0] count;
    logic [7:0]  byte_count;
  } entry_t;

  typedef struct packed {
    logic can_push;
    logic has_entry;
  } qstat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> src/write_coils_frame_checker.sv
// Top level of the write-multiple-coils request checker: configuration registers,
// front end, queue and back end. Depends on wcfc_pkg, wcfc_front, wcfc_queue, wcfc_back.
//
// Takes one request byte per clock on the slave stream (tuser marks the first byte
// of a frame) and emits each masked coil data byte and, after the second CRC byte,
// one verdict on the master stream, each through the queue and the output register.
// The slave stream is stalled only while the queue is full; otherwise the rate is one
// byte per cycle, set by the CRC-16 update, which is unrolled over a whole byte in the
// front end. The queue (two entries by default) and the output register absorb short
// stalls on the master stream. The user must write coil count limits through the
// configuration port while no frame is in flight; the block does not enforce this.
`default_nettype none

module write_coils_frame_checker import wcfc_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                s_axis_tuser,   // [0] frame_start
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [7:0] coil_byte, [18:8] coil_base_index, [21:19] status, [29:22] slave_address,
  // [37:30] function_code, [53:38] start_offset, [69:54] coil_count,
  // [78:70] frame_length, [79] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tuser,   // [0] result_kind
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);

  logic [15:0] min_coil_q, max_coil_q;
  qstat_t      qstat;
  entry_t      push_entry, head_entry;
  logic        push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_coil_q <= MinCoilReset;
      max_coil_q <= MaxCoilReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMinCoil: min_coil_q <= cfg_data_i;
        CfgMaxCoil: max_coil_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  wcfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .rx_byte_i     (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .qstat_i       (qstat),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wcfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  wcfc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .entry_i       (head_entry),
    .pop_o         (pop),
    .min_coil_i    (min_coil_q),
    .max_coil_i    (max_coil_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

>>> src/wcfc_front.sv
// Front end: accepts request bytes, tracks the frame position, runs the CRC and
// captures the header. Depends on wcfc_pkg; feeds wcfc_queue.
`default_nettype none

module wcfc_front import wcfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       frame_start_i,
  input  wire qstat_t     qstat_i,
  output logic            push_o,
  output entry_t          entry_o
);

  logic [8:0]  pos_q, pos_d, pos;
  logic [15:0] crc_q, crc_d, crc_base, crc_next;
  logic [7:0]  slave_q, slave_d, func_q, func_d, bc_q, bc_d, crc_low_q, crc_low_d;
  logic [15:0] offset_q, offset_d, count_q, count_d;
  logic [8:0]  data_end;
  logic        accept, done;
  logic [8:0]  rel_pos;

  assign in_ready_o = qstat_i.can_push;
  assign accept     = in_valid_i && qstat_i.can_push;

  assign pos      = frame_start_i ? 9'd0 : pos_q;
  assign crc_base = frame_start_i ? CrcInit : crc_q;
  assign crc_next = crc16_byte(crc_base, rx_byte_i);
  assign data_end = PosData + {1'b0, bc_q};
  assign done     = pos >= (data_end + 9'd2);
  assign rel_pos  = pos - PosData;

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    slave_d   = slave_q;
    func_d    = func_q;
    offset_d  = offset_q;
    count_d   = count_q;
    bc_d      = bc_q;
    crc_low_d = crc_low_q;
    push_o    = 1'b0;

    entry_o.kind       = KindData;
    entry_o.data       = rx_byte_i;
    entry_o.index      = rel_pos[7:0];
    entry_o.crc_ok     = ({rx_byte_i, crc_low_q} == crc_q);
    entry_o.slave      = slave_q;
    entry_o.func       = func_q;
    entry_o.offset     = offset_q;
    entry_o.count      = count_q;
    entry_o.byte_count = bc_q;

    if (accept) begin
      if (pos >= PosData) begin
        if (!done) begin
          pos_d = pos + 9'd1;
          if (pos < data_end) begin
            crc_d  = crc_next;
            push_o = 1'b1;
          end else if (pos == data_end) begin
            crc_low_d = rx_byte_i;
          end else begin
            push_o       = 1'b1;
            entry_o.kind = KindVerdict;
          end
        end
      end else begin
        pos_d = pos + 9'd1;
        crc_d = crc_next;
        unique case (pos[2:0])
          PosSlave:    slave_d  = rx_byte_i;
          PosFunction: func_d   = rx_byte_i;
          PosOffsetHi: offset_d = {rx_byte_i, offset_q[7:0]};
          PosOffsetLo: offset_d = {offset_q[15:8], rx_byte_i};
          PosCountHi:  count_d  = {rx_byte_i, count_q[7:0]};
          PosCountLo:  count_d  = {count_q[15:8], rx_byte_i};
          default:     bc_d     = rx_byte_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 9'd0;
      crc_q     <= CrcInit;
      slave_q   <= 8'd0;
      func_q    <= 8'd0;
      offset_q  <= 16'd0;
      count_q   <= 16'd0;
      bc_q      <= 8'd0;
      crc_low_q <= 8'd0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      slave_q   <= slave_d;
      func_q    <= func_d;
      offset_q  <= offset_d;
      count_q   <= count_d;
      bc_q      <= bc_d;
      crc_low_q <= crc_low_d;
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= 9'd264)
    else $error("frame position ran past the longest frame");

  a_verdict_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.kind == KindVerdict) |-> (pos == data_end + 9'd1))
    else $error("verdict pushed away from the last CRC byte");

endmodule

`default_nettype wire

>>> src/wcfc_queue.sv
// Short queue between the front end and the back end of the checker.
// Depends on wcfc_pkg for the entry and status types.
`default_nettype none

module wcfc_queue import wcfc_pkg::*; #(
  parameter int unsigned Depth = DefQueueDepth
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      entry_o,
  output qstat_t      qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t            entries_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign qstat_o.can_push  = (cnt_q != CntW'(Depth));
  assign qstat_o.has_entry = (cnt_q != '0);
  assign entry_o           = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q != CntW'(Depth)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("queue read while empty");

endmodule

`default_nettype wire

>>> src/wcfc_back.sv
// Back end: masks coil bytes, evaluates the frame checks and holds the result
// in an output register. Depends on wcfc_pkg; drains wcfc_queue.
`default_nettype none

module wcfc_back import wcfc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire qstat_t              qstat_i,
  input  wire entry_t              entry_i,
  output logic                     pop_o,
  input  wire logic [15:0]         min_coil_i,
  input  wire logic [15:0]         max_coil_i,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tuser
);

  logic        valid_q;
  kind_e       kind_q, kind_d;
  logic [7:0]  coil_q, coil_d;
  logic [10:0] base_q, base_d;
  status_e     status_q, status_d;
  logic [7:0]  slave_q, func_q;
  logic [15:0] offset_q, count_q;
  logic [8:0]  frame_len_q;

  logic [15:0] lim, base16, diff;
  logic [7:0]  mask;
  logic [16:0] need_sum;

  assign pop_o = qstat_i.has_entry && (!valid_q || m_axis_tready);

  always_comb begin
    lim    = (entry_i.count < max_coil_i) ? entry_i.count : max_coil_i;
    base16 = {5'd0, entry_i.index, 3'b000};
    diff   = lim - base16;
    if (lim <= base16) begin
      mask = 8'h00;
    end else if (diff >= 16'd8) begin
      mask = 8'hFF;
    end else begin
      mask = 8'((9'd1 << diff[2:0]) - 9'd1);
    end

    need_sum = {1'b0, entry_i.count} + 17'd7;

    kind_d   = entry_i.kind;
    coil_d   = 8'd0;
    base_d   = 11'd0;
    status_d = StOk;
    if (entry_i.kind == KindData) begin
      coil_d = entry_i.data & mask;
      base_d = {entry_i.index, 3'b000};
    end else begin
      priority if (!entry_i.crc_ok) begin
        status_d = StCrc;
      end else if (entry_i.count < min_coil_i) begin
        status_d = StLow;
      end else if (entry_i.count > max_coil_i) begin
        status_d = StHigh;
      end else if (need_sum[16:3] != {6'd0, entry_i.byte_count}) begin
        status_d = StByteCnt;
      end else begin
        status_d = StOk;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q      <= kind_d;
      coil_q      <= coil_d;
      base_q      <= base_d;
      status_q    <= status_d;
      slave_q     <= entry_i.slave;
      func_q      <= entry_i.func;
      offset_q    <= entry_i.offset;
      count_q     <= entry_i.count;
      frame_len_q <= FrameOverhead + {1'b0, entry_i.byte_count};
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tdata  = {1'b0, frame_len_q, count_q, offset_q, func_q, slave_q,
                          status_q, base_q, coil_q};

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindData) |-> (status_q == StOk))
    else $error("coil data result carries a nonzero status");

  a_verdict_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KindVerdict) |-> (coil_q == 8'd0 && base_q == 11'd0))
    else $error("verdict carries coil bits");

endmodule

`default_nettype wire

>>> dv/tb_write_coils_frame_checker.sv
// Self-checking testbench for write_coils_frame_checker: directed request frames, then random
// frames under several coil count limits, all checked against a cycle-free predictor.
// Depends on wcfc_pkg and the write_coils_frame_checker RTL.
`default_nettype none

module tb_write_coils_frame_checker import wcfc_pkg::*;;

  localparam int unsigned IdleLimit = 4000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ItemsPerPhase = 206;
  localparam int unsigned DrainCycles = 8;

  typedef enum logic [1:0] {SrcRaw, SrcCrcLo, SrcCrcHi} byte_src_e;
  typedef enum logic [1:0] {RxOpen, RxCoin, RxPeriodic, RxSparse} rx_mode_e;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
    byte_src_e  src;
    logic       typed;
    kind_e      kind;
    logic [7:0] coil;
    status_e    status;
  } stim_row_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  coil;
    logic [10:0] base;
    status_e     status;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [15:0] offset;
    logic [15:0] count;
    logic [8:0]  flen;
  } coil_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic s_user = 1'b0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_index = CfgMinCoil;
  logic [15:0] cfg_data = 16'h0000;

  logic s_ready;
  logic m_valid;
  logic [OutDataW-1:0] m_data;
  logic m_user;
  logic cfg_ready;

  write_coils_frame_checker dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state and its copy of the coil count limits.
  logic [8:0]  pos_q = 9'd0;
  logic [15:0] crc_q = CrcInit;
  logic [7:0]  slave_q = 8'h00;
  logic [7:0]  func_q = 8'h00;
  logic [15:0] offset_q = 16'h0000;
  logic [15:0] count_q = 16'h0000;
  logic [7:0]  bcnt_q = 8'h00;
  logic [7:0]  crc_lo_q = 8'h00;
  logic [15:0] min_q = MinCoilReset;
  logic [15:0] max_q = MaxCoilReset;

  coil_result_t coil_results_due[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_pushed = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned rx_hold_left = 0;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_e rx_mode = RxOpen;

  stim_row_t directed_rows [22] = '{
    // No frame flag after reset: the bytes still form a frame.
    '{8'h00, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h0F, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h01, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h01, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b1, KindData,    8'h01, StOk},
    '{8'h00, 1'b0, SrcCrcLo, 1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcCrcHi, 1'b1, KindVerdict, 8'h00, StOk},
    // A frame cut short by a new frame flag.
    '{8'hFF, 1'b1, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h0F, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b1, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'hFF, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcCrcLo, 1'b0, KindData,    8'h00, StOk},
    '{8'h00, 1'b0, SrcCrcHi, 1'b1, KindVerdict, 8'h00, StHigh},
    // Bytes after the verdict without a frame flag are dropped.
    '{8'h55, 1'b0, SrcRaw,   1'b0, KindData,    8'h00, StOk}
  };

  function automatic logic [15:0] crc16_modbus_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = (c >> 1) ^ (c[0] ? 16'hA001 : 16'h0000);
    return c;
  endfunction

  task automatic parse_request_byte(input logic [7:0] b, input logic first);
    int unsigned dend;
    int unsigned base;
    logic [7:0] mask;
    logic [16:0] need;
    coil_result_t r;
    if (first) begin
      pos_q = 9'd0;
      crc_q = CrcInit;
    end
    if (pos_q >= PosData) begin
      dend = 32'(PosData) + 32'(bcnt_q);
      if (32'(pos_q) >= dend + 2) return;
      r.slave = slave_q;
      r.func = func_q;
      r.offset = offset_q;
      r.count = count_q;
      r.flen = FrameOverhead + {1'b0, bcnt_q};
      if (32'(pos_q) < dend) begin
        base = (32'(pos_q) - 32'(PosData)) * 8;
        mask = 8'h00;
        for (int k = 0; k < 8; k++) begin
          if (base + k < 32'(count_q) && base + k < 32'(max_q)) mask[k] = 1'b1;
        end
        crc_q = crc16_modbus_next(crc_q, b);
        r.kind = KindData;
        r.coil = b & mask;
        r.base = base[10:0];
        r.status = StOk;
        coil_results_due.push_back(r);
        results_pushed++;
      end else if (32'(pos_q) == dend) begin
        crc_lo_q = b;
      end else begin
        need = ({1'b0, count_q} + 17'd7) >> 3;
        r.kind = KindVerdict;
        r.coil = 8'h00;
        r.base = 11'd0;
        if ({b, crc_lo_q} != crc_q) r.status = StCrc;
        else if (count_q < min_q) r.status = StLow;
        else if (count_q > max_q) r.status = StHigh;
        else if (need != {9'd0, bcnt_q}) r.status = StByteCnt;
        else r.status = StOk;
        coil_results_due.push_back(r);
        results_pushed++;
      end
    end else begin
      crc_q = crc16_modbus_next(crc_q, b);
      case (pos_q[2:0])
        PosSlave: slave_q = b;
        PosFunction: func_q = b;
        PosOffsetHi: offset_q[15:8] = b;
        PosOffsetLo: offset_q[7:0] = b;
        PosCountHi: count_q[15:8] = b;
        PosCountLo: count_q[7:0] = b;
        default: bcnt_q = b;
      endcase
    end
    pos_q = pos_q + 9'd1;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= first;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    parse_request_byte(b, first);
  endtask

  task automatic sender_stop();
    s_valid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (coil_results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limits(input logic [15:0] lo, input logic [15:0] hi);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CfgMinCoil : CfgMaxCoil;
      cfg_data <= (i == 0) ? lo : hi;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == 0) min_q = lo;
      else max_q = hi;
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_write_coils_request();
    logic [7:0] frame[$];
    logic [15:0] cnt;
    logic [15:0] crc;
    logic [15:0] pivot;
    logic all_ones;
    int unsigned sel;
    int unsigned pick;
    int unsigned need;
    int unsigned bc;
    int unsigned last;
    int unsigned noise;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      cnt = 16'($urandom_range(0, 48));
    end else if (sel < 84) begin
      cnt = 16'($urandom_range(49, 200));
    end else if (sel < 94) begin
      pick = $urandom_range(0, 5);
      pivot = (pick < 3) ? min_q : max_q;
      cnt = pivot + 16'(pick % 3) - 16'd1;
    end else if (sel < 99) begin
      cnt = 16'($urandom);
    end else begin
      cnt = 16'd2040 - 16'($urandom_range(0, 7));
    end
    need = (int'(cnt) + 7) / 8;
    if (need > 255 || (need > 40 && sel >= 84 && sel < 99)) bc = $urandom_range(0, 12);
    else bc = need;
    if ($urandom_range(0, 9) == 0) begin
      if (bc == 0 || (bc < 255 && $urandom_range(0, 1) == 1)) bc = bc + 1;
      else bc = bc - 1;
    end
    frame.push_back(8'($urandom));
    frame.push_back(($urandom_range(0, 6) == 0) ? 8'($urandom) : 8'h0F);
    frame.push_back(8'($urandom));
    frame.push_back(8'($urandom));
    frame.push_back(cnt[15:8]);
    frame.push_back(cnt[7:0]);
    frame.push_back(bc[7:0]);
    all_ones = ($urandom_range(0, 4) == 0);
    for (int k = 0; k < bc; k++) frame.push_back(all_ones ? 8'hFF : 8'($urandom));
    crc = CrcInit;
    foreach (frame[k]) crc = crc16_modbus_next(crc, frame[k]);
    if ($urandom_range(0, 9) == 0) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    noise = $urandom_range(0, 99);
    last = (noise < 5) ? $urandom_range(1, frame.size() - 1) : frame.size();
    for (int k = 0; k < last; k++) begin
      send_byte(frame[k], (k == 0) && (noise < 5 || noise > 7));
    end
    if (noise >= 90) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    coil_result_t want;
    coil_result_t got;
    if (rst_n && m_valid && m_ready) begin
      got.kind = kind_e'(m_user);
      got.coil = m_data[7:0];
      got.base = m_data[18:8];
      got.status = status_e'(m_data[21:19]);
      got.slave = m_data[29:22];
      got.func = m_data[37:30];
      got.offset = m_data[53:38];
      got.count = m_data[69:54];
      got.flen = m_data[78:70];
      if (coil_results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
      end else begin
        want = coil_results_due.pop_front();
        check_field("result_kind", 16'(want.kind), 16'(got.kind));
        check_field("coil_byte", 16'(want.coil), 16'(got.coil));
        check_field("coil_base_index", 16'(want.base), 16'(got.base));
        check_field("status", 16'(want.status), 16'(got.status));
        check_field("slave_address", 16'(want.slave), 16'(got.slave));
        check_field("function_code", 16'(want.func), 16'(got.func));
        check_field("start_offset", want.offset, got.offset);
        check_field("coil_count", want.count, got.count);
        check_field("frame_length", 16'(want.flen), 16'(got.flen));
        check_field("tdata padding", 16'h0000, 16'(m_data[79]));
      end
    end
  end

  // The long hold-off is counted here so that the sender keeps offering bytes meanwhile.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_ready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      rx_hold_left = HoldCycles;
      m_ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 200);
      end
      rx_mode_left--;
      case (rx_mode)
        RxOpen: m_ready <= 1'b1;
        RxCoin: m_ready <= 1'($urandom_range(0, 1));
        RxPeriodic: m_ready <= (rx_tick % 4) != 0;
        default: m_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("FAIL write_coils_frame_checker");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    coil_result_t typed_result;
    logic [7:0] b;
    int unsigned depth0;
    logic [15:0] phase_min [8];
    logic [15:0] phase_max [8];
    phase_min = '{16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd8, 16'd3, 16'd0, 16'd0};
    phase_max = '{16'd1968, 16'hFFFF, 16'd0, 16'd0, 16'd16, 16'd40, 16'd0, 16'd0};
    phase_min[6] = 16'($urandom_range(0, 64));
    phase_max[6] = 16'($urandom_range(0, 2040));
    phase_min[7] = 16'($urandom_range(0, 16));
    phase_max[7] = 16'($urandom_range(64, 300));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.src)
        SrcCrcLo: b = crc_q[7:0];
        SrcCrcHi: b = crc_q[15:8];
        default: b = row.value;
      endcase
      depth0 = results_pushed;
      send_byte(b, row.first);
      if (row.typed && results_pushed == depth0 + 1) begin
        typed_result = coil_results_due.pop_back();
        typed_result.kind = row.kind;
        typed_result.coil = row.coil;
        typed_result.base = 11'd0;
        typed_result.status = row.status;
        coil_results_due.push_back(typed_result);
      end
    end
    sender_stop();
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_limits(phase_min[p], phase_max[p]);
      if (p == 3) hold_asked++;
      while (items_sent < (p + 1) * ItemsPerPhase + $size(directed_rows)) begin
        send_write_coils_request();
      end
      sender_stop();
      wait_drained();
    end

    if (coil_results_due.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived, expected %h, actual none", $time,
               coil_results_due.size(), coil_results_due[0]);
    end
    if (errors == 0) begin
      $display("PASS write_coils_frame_checker");
    end else begin
      $display("FAIL write_coils_frame_checker");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/wcfc_pkg.sv
src/wcfc_front.sv
src/wcfc_queue.sv
src/wcfc_back.sv
src/write_coils_frame_checker.sv
dv/tb_write_coils_frame_checker.sv
